// ===== rtl/lff_pkg.sv =====
// shared types, constants and level mapping for the line follower fallback controller
package lff_pkg;

    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // level = (1023 - raw + offset) * 220 / 623, saturated at 255
    // spans of 725 and up always saturate; below that the quotient is an exact
    // reciprocal multiply: 220 * ceil(2^28 / 623) then a shift by 28
    localparam logic [9:0]  MAP_FULL     = 10'd1023;
    localparam logic [10:0] MAP_SAT_SPAN = 11'd725;
    localparam logic [36:0] MAP_MUL      = 37'd94792720;
    localparam int          MAP_SHIFT    = 28;

    // configuration register indexes
    localparam logic [2:0] CFG_LOW_LIGHT  = 3'd0;
    localparam logic [2:0] CFG_HIGH_LIGHT = 3'd1;
    localparam logic [2:0] CFG_STEER_MARG = 3'd2;
    localparam logic [2:0] CFG_LOST_LIMIT = 3'd3;
    localparam logic [2:0] CFG_FB_DUTY    = 3'd4;
    localparam logic [2:0] CFG_RIGHT_OFS  = 3'd5;

    // configuration reset values
    localparam logic [7:0] RST_LOW_LIGHT  = 8'd75;
    localparam logic [7:0] RST_HIGH_LIGHT = 8'd220;
    localparam logic [7:0] RST_STEER_MARG = 8'd60;
    localparam logic [3:0] RST_LOST_LIMIT = 4'd3;
    localparam logic [7:0] RST_FB_DUTY    = 8'd200;
    localparam logic [9:0] RST_RIGHT_OFS  = 10'd100;

    typedef enum logic [1:0] {
        STEER_LEFT     = 2'd0,
        STEER_STRAIGHT = 2'd1,
        STEER_RIGHT    = 2'd2
    } steer_t;

    function automatic logic [LEVEL_W-1:0] to_level(input logic [9:0] raw,
                                                    input logic [9:0] offset);
        logic [10:0] span;
        logic [36:0] prod;
        logic [LEVEL_W-1:0] lvl;
        span = 11'(MAP_FULL) - 11'(raw) + 11'(offset);
        prod = 37'(span[9:0]) * MAP_MUL;
        if (span >= MAP_SAT_SPAN)
        begin
            lvl = LEVEL_MAX;
        end
        else
        begin
            lvl = prod[MAP_SHIFT +: LEVEL_W];
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/lff_window.sv =====
// sliding window of levels with a running sum and the truncated window average
module lff_window
    import lff_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [LEVEL_W-1:0] level,
    output logic [LEVEL_W-1:0] average
);

    localparam int SUM_W     = $clog2(WINDOW * 255 + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP     = (2 ** DIV_SHIFT + WINDOW - 1) / WINDOW;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = SUM_W + RECIP_W;

    logic [LEVEL_W-1:0] win_reg [WINDOW];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [PROD_W-1:0]  quot_prod;

    // oldest entry leaves, new level enters
    assign sum_next  = sum_reg - SUM_W'(win_reg[WINDOW-1]) + SUM_W'(level);
    // exact divide by the window depth: sum never reaches 2^SUM_W
    assign quot_prod = PROD_W'(sum_next) * PROD_W'(RECIP);
    assign average   = quot_prod[DIV_SHIFT +: LEVEL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            sum_reg    <= sum_next;
            win_reg[0] <= level;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

// ===== rtl/line_follower_fallback_controller.sv =====
// line follower controller: sensor levels, window averages, lost hysteresis, motor drive
//
// Input channel: in_valid / in_stall carries one pair of 10-bit light samples
// (left_raw, right_raw). Output channel: out_valid / out_stall carries one
// result per pair: duty and brake per motor, fallback flag, latched steering
// and both window averages. A transfer happens on a clock edge with valid high
// and stall low. Configuration is a write port (cfg_write, cfg_index, cfg_data);
// write only while no pair is in flight.
// A pair accepted is mapped into the level register, then moves into the output
// register once that is free, and its result is presented from there. One pair
// is taken every cycle while the receiver does not stall; the limit is the window
// sum update, the divide by the window depth and the mode update, all done
// between the level register and the output register.
// Reset clears both windows and sums, the lost counter and fallback mode, sets
// steering to straight and loads the default limits; no result is valid.
// When the receiver stalls, the output register holds; the level register
// holds its pair, and in_stall rises once that register is full as well.
module line_follower_fallback_controller
    import lff_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [9:0]   left_raw,
    input  logic [9:0]   right_raw,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   left_duty,
    output logic         left_brake,
    output logic [7:0]   right_duty,
    output logic         right_brake,
    output logic         fallback_on,
    output logic [1:0]   steer_dir,
    output logic [7:0]   left_level,
    output logic [7:0]   right_level,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [9:0]   cfg_data
);

    logic [7:0] low_light_reg;
    logic [7:0] high_light_reg;
    logic [7:0] steer_marg_reg;
    logic [3:0] lost_limit_reg;
    logic [7:0] fb_duty_reg;
    logic [9:0] right_ofs_reg;

    logic               a_valid_reg;
    logic [LEVEL_W-1:0] left_lvl_reg;
    logic [LEVEL_W-1:0] right_lvl_reg;

    logic [3:0] lost_cnt_reg;
    logic [3:0] lost_cnt_next;
    logic       fallback_reg;
    logic       fallback_next;
    steer_t     steer_reg;
    steer_t     steer_next;

    logic       out_valid_reg;
    logic [7:0] left_duty_reg;
    logic       left_brake_reg;
    logic [7:0] right_duty_reg;
    logic       right_brake_reg;
    logic [7:0] left_level_reg;
    logic [7:0] right_level_reg;

    logic       in_take;
    logic       a_move;
    logic [7:0] left_avg;
    logic [7:0] right_avg;
    logic [7:0] mean;
    logic       qualify;
    logic [4:0] cnt_inc;
    logic [4:0] cnt_cand;
    logic       toggle;
    logic [7:0] ld;
    logic [7:0] rd;
    logic       lb;
    logic       rb;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_light_reg  <= RST_LOW_LIGHT;
            high_light_reg <= RST_HIGH_LIGHT;
            steer_marg_reg <= RST_STEER_MARG;
            lost_limit_reg <= RST_LOST_LIMIT;
            fb_duty_reg    <= RST_FB_DUTY;
            right_ofs_reg  <= RST_RIGHT_OFS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LOW_LIGHT:  low_light_reg  <= cfg_data[7:0];
                CFG_HIGH_LIGHT: high_light_reg <= cfg_data[7:0];
                CFG_STEER_MARG: steer_marg_reg <= cfg_data[7:0];
                CFG_LOST_LIMIT: lost_limit_reg <= cfg_data[3:0];
                CFG_FB_DUTY:    fb_duty_reg    <= cfg_data[7:0];
                CFG_RIGHT_OFS:  right_ofs_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // handshake: level register moves on when the output register is free
    assign a_move   = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !a_move;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_take || (a_valid_reg && !a_move);
        end
    end

    // sample mapping happens on the way into the level register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_lvl_reg  <= to_level(left_raw, 10'd0);
            right_lvl_reg <= to_level(right_raw, right_ofs_reg);
        end
    end

    lff_window #(.WINDOW(WINDOW)) u_left_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (a_move),
        .level   (left_lvl_reg),
        .average (left_avg)
    );

    lff_window #(.WINDOW(WINDOW)) u_right_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (a_move),
        .level   (right_lvl_reg),
        .average (right_avg)
    );

    // lost hysteresis and steering
    always_comb
    begin
        mean = 8'((9'(left_avg) + 9'(right_avg)) >> 1);
        if (fallback_reg)
        begin
            qualify = (mean > low_light_reg) && (mean < high_light_reg);
        end
        else
        begin
            qualify = (mean < low_light_reg) || (mean > high_light_reg);
        end
        cnt_inc  = 5'(lost_cnt_reg) + 5'd1;
        cnt_cand = qualify ? cnt_inc : 5'd0;
        toggle   = cnt_cand > 5'(lost_limit_reg);
        fallback_next = fallback_reg ^ toggle;
        lost_cnt_next = toggle ? 4'd0 : cnt_cand[3:0];

        steer_next = steer_reg;
        if (!fallback_next)
        begin
            if (9'(right_avg) > 9'(left_avg) + 9'(steer_marg_reg))
            begin
                steer_next = STEER_RIGHT;
            end
            else if (9'(left_avg) > 9'(right_avg) + 9'(steer_marg_reg))
            begin
                steer_next = STEER_LEFT;
            end
            else
            begin
                steer_next = STEER_STRAIGHT;
            end
        end

        lb = 1'b0;
        rb = 1'b0;
        if (!fallback_next)
        begin
            ld = left_avg;
            rd = right_avg;
        end
        else
        begin
            case (steer_next)
                STEER_LEFT:
                begin
                    ld = fb_duty_reg;
                    rd = LEVEL_MAX;
                    rb = 1'b1;
                end
                STEER_RIGHT:
                begin
                    ld = LEVEL_MAX;
                    lb = 1'b1;
                    rd = fb_duty_reg;
                end
                default:
                begin
                    ld = fb_duty_reg;
                    rd = fb_duty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_cnt_reg  <= 4'd0;
            fallback_reg  <= 1'b0;
            steer_reg     <= STEER_STRAIGHT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_move)
            begin
                lost_cnt_reg <= lost_cnt_next;
                fallback_reg <= fallback_next;
                steer_reg    <= steer_next;
            end
            if (a_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            left_duty_reg   <= ld;
            left_brake_reg  <= lb;
            right_duty_reg  <= rd;
            right_brake_reg <= rb;
            left_level_reg  <= left_avg;
            right_level_reg <= right_avg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_duty   = left_duty_reg;
    assign left_brake  = left_brake_reg;
    assign right_duty  = right_duty_reg;
    assign right_brake = right_brake_reg;
    assign fallback_on = fallback_reg;
    assign steer_dir   = steer_reg;
    assign left_level  = left_level_reg;
    assign right_level = right_level_reg;

    // a mode change always leaves the lost counter cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (fallback_reg != $past(fallback_reg)) |-> (lost_cnt_reg == 4'd0))
        else $error("lost counter not cleared on mode change");

    // no brake while following the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fallback_on) |-> (!left_brake && !right_brake))
        else $error("brake while following line");

    // a braking side always reports full duty, and never both sides
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (left_brake || right_brake)) |->
            (!(left_brake && right_brake) &&
             (!left_brake || left_duty == LEVEL_MAX) &&
             (!right_brake || right_duty == LEVEL_MAX)))
        else $error("inconsistent brake outputs");

    // input is held back only while the level register holds an unmoved pair
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

endmodule
